// ----- sv/rmth_pkg.sv -----
// Package with shared types, constants and helpers for the running median block.
package rmth_pkg;

  localparam int unsigned HALF_DEPTH_DEFAULT = 512;
  localparam int unsigned VALUE_BITS_DEFAULT = 32;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned MEDIAN_BITS = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_PUSH_WR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_BAL,
    ST_BAL_RD,
    ST_MOVE_RD,
    ST_DOWN_RD,
    ST_DOWN_RD2,
    ST_DOWN_CMP,
    ST_FIN,
    ST_DONE
  } state_t;

  // True when a belongs above b: max-heap when is_max, else min-heap.
  function automatic logic above_f(input logic is_max, input logic [63:0] a,
                                   input logic [63:0] b);
    above_f = is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ----- sv/running_median_two_heaps.sv -----
// Top level of the running median block built on two heap memories.
//
// The block keeps a max-heap of the lower half and a min-heap of the upper
// half of all samples since the last restart, each in its own single-port-read
// synchronous memory of HALF_DEPTH words. Pulse start with restart and sample
// while busy is low; the block raises busy and, when done, shows median and
// overflow for exactly one cycle with done high. The receiver cannot stall,
// so the result must be taken in that cycle. An item first fetches the lower
// top and places the sample, sifts it up one heap level per read and
// compare, tests the balance, then fetches both tops and presents the
// result. A rebalance adds a fetch of the moved top, a second sift-up, a
// fetch of the last entry of the donor heap and a sift-down; busy falls in
// the cycle after done. Every step is a memory read-compare-write, and the
// registered read of the heap memories sets the cost of each level. No
// clearing pass is needed after reset: only entries below the counts are
// read. A sample whose heap is full is dropped and reported with overflow
// high and the old median.
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int unsigned HALF_DEPTH = HALF_DEPTH_DEFAULT,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   restart,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   done,
  output logic [MEDIAN_BITS-1:0] median,
  output logic                   overflow
);

  localparam int unsigned AW = $clog2(HALF_DEPTH);
  localparam int unsigned CW = $clog2(HALF_DEPTH + 1);
  localparam int unsigned XW = CW + 1;

  state_t state, state_next;

  // Counts of both heaps.
  logic [CW-1:0] lcount, ucount;
  // Which heap the running sift works on: 1 selects the lower (max) heap.
  logic          sel;
  logic [VALUE_BITS-1:0] val;     // value being sifted
  logic [CW-1:0] pos;             // current slot of the sifted value
  logic [CW-1:0] heap_n;          // heap size during sift-down
  logic [VALUE_BITS-1:0] child_l; // left child captured during sift-down
  logic          ovf;
  logic          move_pend;       // a pop follows the current push

  // Memory ports.
  logic                  l_we, u_we;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, l_rdata, u_rdata, rdata;

  rmth_mem #(.DEPTH(HALF_DEPTH), .WIDTH(VALUE_BITS)) u_lower (
    .clk(clk), .we(l_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(l_rdata)
  );

  rmth_mem #(.DEPTH(HALF_DEPTH), .WIDTH(VALUE_BITS)) u_upper (
    .clk(clk), .we(u_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(u_rdata)
  );

  logic rd_sel;
  assign rdata = rd_sel ? l_rdata : u_rdata;

  // Parent index and child indexes, widened to hold one past the end.
  logic [CW-1:0] parent;
  logic [XW-1:0] lchild, rchild;
  assign parent = (pos - CW'(1)) >> 1;
  assign lchild = {pos, 1'b1};
  assign rchild = lchild + XW'(1);

  logic [63:0] val_w, rd_w, cl_w;
  assign val_w = 64'(val);
  assign rd_w  = 64'(rdata);
  assign cl_w  = 64'(child_l);

  logic lower_bigger, upper_bigger;
  assign lower_bigger = XW'(lcount) > XW'(ucount) + XW'(1);
  assign upper_bigger = XW'(ucount) > XW'(lcount) + XW'(1);

  logic [VALUE_BITS-1:0] in_val;
  assign in_val = VALUE_BITS'(64'(sample));

  // Child comparison during sift-down: pick the child that belongs on top.
  logic has_r, r_wins;
  logic [VALUE_BITS-1:0] best_val;
  assign has_r    = rchild < XW'(heap_n);
  assign r_wins   = has_r && above_f(sel, rd_w, cl_w);
  assign best_val = r_wins ? rdata : child_l;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_TOP_RD;
      ST_TOP_RD:   state_next = ST_TOP_WAIT;
      ST_TOP_WAIT: state_next = ST_PUSH_WR;
      ST_PUSH_WR:  state_next = ovf ? ST_DONE : ST_UP_RD;
      ST_UP_RD:    state_next = (pos == '0) ? (move_pend ? ST_MOVE_RD : ST_BAL)
                                            : ST_UP_CMP;
      ST_UP_CMP:   state_next = above_f(sel, val_w, rd_w) ? ST_UP_RD
                                : (move_pend ? ST_MOVE_RD : ST_BAL);
      ST_BAL:      state_next = (lower_bigger || upper_bigger) ? ST_BAL_RD : ST_FIN;
      ST_BAL_RD:   state_next = ST_UP_RD;
      ST_MOVE_RD:  state_next = ST_DOWN_RD;
      ST_DOWN_RD:  state_next = (lchild < XW'(heap_n)) ? ST_DOWN_RD2 : ST_FIN;
      ST_DOWN_RD2: state_next = ST_DOWN_CMP;
      ST_DOWN_CMP: state_next = (above_f(sel, 64'(best_val), val_w)) ? ST_DOWN_RD
                                                                     : ST_FIN;
      ST_FIN:      state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory controls and outputs.
  always_comb begin
    l_we   = 1'b0;
    u_we   = 1'b0;
    waddr  = '0;
    wdata  = val;
    raddr  = '0;
    rd_sel = sel;
    busy   = (state != ST_IDLE);
    done   = (state == ST_DONE);
    case (state)
      ST_IDLE: begin
        raddr  = '0;
        rd_sel = 1'b1;
      end
      ST_TOP_RD, ST_TOP_WAIT: begin
        raddr  = '0;
        rd_sel = 1'b1;
      end
      ST_PUSH_WR: begin
        waddr = AW'(pos);
        l_we  = !ovf && sel;
        u_we  = !ovf && !sel;
      end
      ST_UP_RD: begin
        // The sifted value sits in the current slot until it climbs further.
        raddr = AW'(parent);
        waddr = AW'(pos);
        l_we  = sel;
        u_we  = !sel;
      end
      ST_UP_CMP: begin
        raddr = AW'(parent);
        if (above_f(sel, val_w, rd_w)) begin
          // Parent moves down into the current slot, value moves up.
          waddr = AW'(pos);
          wdata = rdata;
          l_we  = sel;
          u_we  = !sel;
        end else begin
          waddr = AW'(pos);
          l_we  = sel;
          u_we  = !sel;
        end
      end
      ST_BAL: begin
        // Read the top of the larger heap, to be moved across.
        raddr  = '0;
        rd_sel = lower_bigger;
      end
      ST_MOVE_RD: begin
        // Read the last entry of the donor heap; it becomes the new root.
        raddr = sel ? AW'(ucount - CW'(1)) : AW'(lcount - CW'(1));
      end
      ST_DOWN_RD: begin
        // The sifted value sits in the current slot until it sinks further.
        raddr = AW'(lchild);
        waddr = AW'(pos);
        if (pos == '0 && move_pend) begin
          wdata = rdata;
        end
        l_we = sel;
        u_we = !sel;
      end
      ST_DOWN_RD2: begin
        raddr = AW'(has_r ? rchild : lchild);
      end
      ST_DOWN_CMP: begin
        waddr = AW'(pos);
        if (above_f(sel, 64'(best_val), val_w)) begin
          wdata = best_val;
        end
        l_we = sel;
        u_we = !sel;
      end
      ST_FIN: begin
        // Fetch both tops for the median shown in the next cycle.
        raddr  = '0;
        rd_sel = 1'b1;
      end
      ST_DONE: begin
        raddr  = '0;
        rd_sel = 1'b1;
      end
      default: ;
    endcase
  end

  // Tops of both heaps, read at address zero in the cycle before completion.
  logic [VALUE_BITS-1:0] lower_top, upper_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcount    <= '0;
      ucount    <= '0;
      move_pend <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      state   <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            val       <= in_val;
            move_pend <= 1'b0;
            if (restart) begin
              lcount <= '0;
              ucount <= '0;
            end
          end
        end
        ST_TOP_WAIT: begin
          // rdata holds the lower top.
          if (lcount == '0 || val >= rdata) begin
            sel <= 1'b0;
            pos <= ucount;
            ovf <= (ucount >= CW'(HALF_DEPTH));
            if (ucount < CW'(HALF_DEPTH)) ucount <= ucount + CW'(1);
          end else begin
            sel <= 1'b1;
            pos <= lcount;
            ovf <= (lcount >= CW'(HALF_DEPTH));
            if (lcount < CW'(HALF_DEPTH)) lcount <= lcount + CW'(1);
          end
        end
        ST_UP_CMP: begin
          if (above_f(sel, val_w, rd_w)) pos <= parent;
        end
        ST_BAL_RD: begin
          if (lower_bigger) begin
            // Pop lower later; push its top into upper first.
            val       <= l_rdata;
            sel       <= 1'b0;
            pos       <= ucount;
            ucount    <= ucount + CW'(1);
            move_pend <= 1'b1;
          end else if (upper_bigger) begin
            val       <= u_rdata;
            sel       <= 1'b1;
            pos       <= lcount;
            lcount    <= lcount + CW'(1);
            move_pend <= 1'b1;
          end
        end
        ST_MOVE_RD: begin
          // Switch to the donor heap and shrink it.
          sel <= !sel;
          pos <= '0;
          if (sel) begin
            heap_n <= ucount - CW'(1);
            ucount <= ucount - CW'(1);
          end else begin
            heap_n <= lcount - CW'(1);
            lcount <= lcount - CW'(1);
          end
        end
        ST_DOWN_RD: begin
          // The first pass delivers the last entry as the sifted value.
          if (pos == '0 && move_pend) begin
            val       <= rdata;
            move_pend <= 1'b0;
          end
        end
        ST_DOWN_RD2: begin
          child_l <= rdata;
        end
        ST_DOWN_CMP: begin
          if (above_f(sel, 64'(best_val), val_w)) begin
            pos <= r_wins ? CW'(rchild) : CW'(lchild);
          end
        end
        default: ;
      endcase
    end
  end

  assign lower_top = l_rdata;
  assign upper_top = u_rdata;

  always_comb begin
    if (lcount == '0 && ucount == '0) begin
      median = '0;
    end else if (lcount >= ucount) begin
      median = MEDIAN_BITS'(64'(lower_top));
    end else begin
      median = MEDIAN_BITS'(64'(upper_top));
    end
  end
  assign overflow = ovf;

endmodule

// ----- sv/rmth_mem.sv -----
// Synchronous heap memory with one read port and one write port.
module rmth_mem
  import rmth_pkg::*;
#(
  parameter int unsigned DEPTH = HALF_DEPTH_DEFAULT,
  parameter int unsigned WIDTH = VALUE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rmth_checker.sv -----
// Port-level checker for the running median block, bound to the top level.
module rmth_checker
  import rmth_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic overflow
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy stayed after result");
  a_ovf_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(overflow)) else $error("overflow unknown with result");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .overflow(overflow)
);

// ----- verif/running_median_two_heaps_tb.sv -----
// Self-checking testbench for the two-heap running median block.
module running_median_two_heaps_tb;
  import rmth_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = HALF_DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 220;
  // The limit takes the worst case per item, plus the sender gap between
  // items, several times over.
  localparam longint unsigned CYCLE_LIMIT = 64'd1000000;

  typedef struct packed {
    logic        restart;
    logic [31:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic [31:0] median;
    logic        overflow;
  } median_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        restart;
  logic [31:0] sample;
  logic        done;
  logic [31:0] median;
  logic        overflow;

  running_median_two_heaps dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .restart  (restart),
    .sample   (sample),
    .done     (done),
    .median   (median),
    .overflow (overflow)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state: two heaps held as plain arrays, the lower one a max-heap
  // and the upper one a min-heap, exactly as the block keeps them.
  logic [31:0] low_heap [DEPTH];
  logic [31:0] high_heap [DEPTH];
  int unsigned low_size = 0;
  int unsigned high_size = 0;

  sample_item_t   pending_samples[$];
  median_result_t expected_medians[$];
  int unsigned    error_count = 0;
  int unsigned    accepted_count = 0;
  int unsigned    total_items = 0;
  longint unsigned cycle_count = 0;

  // A sits above b in a max-heap when greater, in a min-heap when smaller.
  function automatic bit ranks_above(bit is_max, logic [31:0] a, logic [31:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_insert(bit is_max, logic [31:0] v);
    int unsigned j;
    int unsigned k;
    logic [31:0] t;
    if (is_max) begin
      j = low_size;
      low_heap[j] = v;
      low_size++;
      while (j > 0) begin
        k = (j - 1) / 2;
        if (!ranks_above(1'b1, low_heap[j], low_heap[k])) break;
        t = low_heap[j]; low_heap[j] = low_heap[k]; low_heap[k] = t;
        j = k;
      end
    end else begin
      j = high_size;
      high_heap[j] = v;
      high_size++;
      while (j > 0) begin
        k = (j - 1) / 2;
        if (!ranks_above(1'b0, high_heap[j], high_heap[k])) break;
        t = high_heap[j]; high_heap[j] = high_heap[k]; high_heap[k] = t;
        j = k;
      end
    end
  endtask

  // Removes the top: the last entry moves to the root and sinks, comparing
  // only children that exist.
  task automatic heap_remove_top(bit is_max);
    int unsigned n;
    int unsigned p;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    logic [31:0] h [DEPTH];
    logic [31:0] t;
    if (is_max) begin
      h = low_heap;
      n = low_size;
    end else begin
      h = high_heap;
      n = high_size;
    end
    p = 0;
    n--;
    h[0] = h[n];
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      best = p;
      if (l < n && ranks_above(is_max, h[l], h[best])) best = l;
      if (r < n && ranks_above(is_max, h[r], h[best]) && ranks_above(is_max, h[r], h[l]))
        best = r;
      if (best == p) break;
      t = h[p]; h[p] = h[best]; h[best] = t;
      p = best;
    end
    if (is_max) begin
      low_heap = h;
      low_size = n;
    end else begin
      high_heap = h;
      high_size = n;
    end
  endtask

  // Applies one accepted transfer and returns the result the block must give.
  task automatic predict_median(sample_item_t it, output median_result_t res);
    bit dropped;
    dropped = 1'b0;
    if (it.restart) begin
      low_size = 0;
      high_size = 0;
    end
    if (low_size == 0 || it.sample >= low_heap[0]) begin
      if (high_size >= DEPTH) dropped = 1'b1;
      else heap_insert(1'b0, it.sample);
    end else begin
      if (low_size >= DEPTH) dropped = 1'b1;
      else heap_insert(1'b1, it.sample);
    end
    if (!dropped) begin
      if (low_size > high_size + 1) begin
        heap_insert(1'b0, low_heap[0]);
        heap_remove_top(1'b1);
      end else if (high_size > low_size + 1) begin
        heap_insert(1'b1, high_heap[0]);
        heap_remove_top(1'b0);
      end
    end
    res.overflow = dropped;
    if (low_size == 0 && high_size == 0) res.median = '0;
    else if (low_size >= high_size) res.median = low_heap[0];
    else res.median = high_heap[0];
  endtask

  function automatic sample_item_t make_item(bit rs, logic [31:0] v);
    sample_item_t it;
    it.restart = rs;
    it.sample = v;
    return it;
  endfunction

  // Random values mostly fall in a narrow band so that duplicates are common,
  // with some full-range values to toggle every bit.
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 15);
      2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom_range(1000, 1100);
    endcase
  endfunction

  // Stimulus. The directed part covers both extremes, duplicates, a restart
  // on the very first item and in mid-run, and a single value after restart.
  // The random part is built from runs of random length, each opened by a
  // restart, and one long run fills both heaps so that samples get dropped
  // with overflow on either side.
  initial begin
    int unsigned ramp;
    pending_samples.push_back(make_item(1'b1, 32'h0000_0000));
    pending_samples.push_back(make_item(1'b0, 32'hFFFF_FFFF));
    pending_samples.push_back(make_item(1'b0, 32'h0000_0000));
    pending_samples.push_back(make_item(1'b0, 32'hFFFF_FFFF));
    pending_samples.push_back(make_item(1'b0, 32'h8000_0000));
    pending_samples.push_back(make_item(1'b0, 32'h8000_0000));
    pending_samples.push_back(make_item(1'b0, 32'h7FFF_FFFF));
    pending_samples.push_back(make_item(1'b0, 32'h0000_0001));
    pending_samples.push_back(make_item(1'b0, 32'hFFFF_FFFE));
    pending_samples.push_back(make_item(1'b0, 32'h5555_5555));
    pending_samples.push_back(make_item(1'b0, 32'hAAAA_AAAA));
    pending_samples.push_back(make_item(1'b1, 32'h1234_5678));
    pending_samples.push_back(make_item(1'b1, 32'h0000_0005));
    pending_samples.push_back(make_item(1'b0, 32'h0000_0003));
    pending_samples.push_back(make_item(1'b0, 32'h0000_0003));
    pending_samples.push_back(make_item(1'b0, 32'h0000_0009));
    while (pending_samples.size() < 16 + RANDOM_ITEMS) begin
      int unsigned run_len;
      run_len = $urandom_range(1, 60);
      pending_samples.push_back(make_item(1'b1, random_value()));
      for (int i = 1; i < run_len; i++)
        pending_samples.push_back(make_item($urandom_range(0, 49) == 0, random_value()));
    end
    // Fill run: an ascending ramp leaves the upper heap full and the lower
    // heap one short, then small and large samples alternate so that both
    // sides see a full heap.
    pending_samples.push_back(make_item(1'b1, 32'd5000));
    for (int unsigned i = 1; i < 2 * DEPTH - 1; i++) begin
      ramp = 32'd5000 + i;
      pending_samples.push_back(make_item(1'b0, ramp));
    end
    for (int unsigned i = 0; i < 40; i++) begin
      ramp = (i % 2 == 0) ? 32'd7 : 32'd900000;
      pending_samples.push_back(make_item(1'b0, ramp));
    end
    total_items = pending_samples.size();
  end

  // Driver: holds a transfer on the pins until the block takes it, then waits
  // a random gap; at least a third of the items get no gap.
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      restart <= 1'b0;
      sample  <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        restart <= pending_samples[0].restart;
        sample  <= pending_samples[0].sample;
        start   <= 1'b1;
        void'(pending_samples.pop_front());
      end
    end
  end

  // Acceptance: each transfer taken by the block is run through the predictor.
  always @(posedge clk) begin
    median_result_t res;
    if (!rst && start && !busy) begin
      predict_median(make_item(restart, sample), res);
      expected_medians.push_back(res);
      accepted_count++;
    end
  end

  // Monitor: compares every strobed result with the oldest expectation.
  always @(posedge clk) begin
    median_result_t want;
    if (!rst && done) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result median=%h overflow=%b", $time, median, overflow);
        error_count++;
      end else begin
        want = expected_medians.pop_front();
        if (median !== want.median) begin
          $display("%0t: median expected %h actual %h", $time, want.median, median);
          error_count++;
        end
        if (overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow, overflow);
          error_count++;
        end
      end
    end
  end

  // Cycle counter that guards the whole run against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (total_items != 0 && accepted_count == total_items);
    wait (expected_medians.size() == 0);
    // A drain time on the order of one item's latency catches stray strobes.
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
